// File: hdl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the switch press classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned CfgW   = 8;
  localparam int unsigned EventW = 5;
  localparam int unsigned ClickW = 4;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_DEBOUNCE_MASK = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [1:0] REG_CLICK_WINDOW  = 2'd2;

  localparam logic [CfgW-1:0] RST_DEBOUNCE_MASK = 8'd15;
  localparam logic [CfgW-1:0] RST_LONG_PRESS    = 8'd64;
  localparam logic [CfgW-1:0] RST_CLICK_WINDOW  = 8'd32;

  // Event codes; n short clicks report n+1.
  localparam logic [EventW-1:0] EV_NONE = 5'd0;
  localparam logic [EventW-1:0] EV_LONG = 5'd1;
  localparam logic [EventW-1:0] EV_MAX  = 5'd16;

  localparam logic [ClickW-1:0] CLICK_MAX = 4'd15;

  typedef struct packed {
    logic [CfgW-1:0] debounce_mask;
    logic [CfgW-1:0] long_press_ticks;
    logic [CfgW-1:0] click_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic              was_pressed;
    logic [7:0]        hold_ticks;
    logic              long_press_active;
    logic [7:0]        window_timer;
    logic [ClickW-1:0] click_count;
  } state_t;

endpackage

// File: hdl/switch_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_press_classifier_core
// Debounced push-button classifier reporting long presses and click bursts.
// ----------------------------------------------------------------------------
// Every accepted request carries one raw switch sample and produces exactly
// one registered result: 0 for no event, 1 for a long press, or n+1
// once a burst of n short clicks has ended. The block takes one sample per
// clock cycle; the whole classification is a single level of logic between
// the state registers and the result register, and a new request is taken
// whenever the result register is empty or being drained in the same cycle.
// The switch counts as pressed while any history bit selected by
// debounce_mask is set. A held switch reports a long press each time its
// hold counter reaches long_press_ticks, so the event repeats while held.
// Releasing after a short press opens or extends the click window; the click
// count saturates at 15. Settings are written over the APB port; the user
// must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module switch_press_classifier_core #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Sample requests.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_switch_pressed,
  // Event results.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spc_pkg::EventW-1:0]   out_press_event,
  // Configuration.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spc_pkg::AddrW-1:0]    paddr,
  input  logic [spc_pkg::DataW-1:0]    pwdata,
  output logic [spc_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  spc_pkg::cfg_t               cfg;
  spc_pkg::state_t             state_r;
  spc_pkg::state_t             state_nxt;
  logic [HISTORY_BITS-1:0]     history_r;
  logic [HISTORY_BITS-1:0]     history_nxt;
  logic [spc_pkg::EventW-1:0]  event_nxt;
  logic [spc_pkg::EventW-1:0]  event_r;
  logic                        out_valid_r;
  logic                        accept;

  spc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spc_step #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_step (
    .cfg         (cfg),
    .state       (state_r),
    .history     (history_r),
    .sample      (in_switch_pressed),
    .state_nxt   (state_nxt),
    .history_nxt (history_nxt),
    .press_event (event_nxt)
  );

  // The result register frees up in the same cycle it is drained, so a
  // sample can be taken every cycle while the consumer keeps up.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Classifier state only moves on an accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      history_r <= '0;
    end else if (accept) begin
      state_r   <= state_nxt;
      history_r <= history_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register; it only loads together with a new request.
  always_ff @(posedge clk) begin
    if (accept) begin
      event_r <= event_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_press_event = event_r;

endmodule

// File: hdl/spc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_cfg
// APB register file holding the three classifier settings.
// ----------------------------------------------------------------------------
module spc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spc_pkg::AddrW-1:0]    paddr,
  input  logic [spc_pkg::DataW-1:0]    pwdata,
  output logic [spc_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output spc_pkg::cfg_t                cfg
);

  spc_pkg::cfg_t cfg_r;
  spc_pkg::cfg_t cfg_nxt;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        spc_pkg::REG_DEBOUNCE_MASK: cfg_nxt.debounce_mask      = pwdata[7:0];
        spc_pkg::REG_LONG_PRESS:    cfg_nxt.long_press_ticks   = pwdata[7:0];
        spc_pkg::REG_CLICK_WINDOW:  cfg_nxt.click_window_ticks = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spc_pkg::REG_DEBOUNCE_MASK: prdata = {24'd0, cfg_r.debounce_mask};
      spc_pkg::REG_LONG_PRESS:    prdata = {24'd0, cfg_r.long_press_ticks};
      spc_pkg::REG_CLICK_WINDOW:  prdata = {24'd0, cfg_r.click_window_ticks};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_mask      <= spc_pkg::RST_DEBOUNCE_MASK;
      cfg_r.long_press_ticks   <= spc_pkg::RST_LONG_PRESS;
      cfg_r.click_window_ticks <= spc_pkg::RST_CLICK_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/spc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_step
// Next-state and event logic for one switch sample.
// ----------------------------------------------------------------------------
module spc_step #(
  parameter int unsigned HISTORY_BITS = 8
) (
  input  spc_pkg::cfg_t                   cfg,
  input  spc_pkg::state_t                 state,
  input  logic [HISTORY_BITS-1:0]         history,
  input  logic                            sample,
  output spc_pkg::state_t                 state_nxt,
  output logic [HISTORY_BITS-1:0]         history_nxt,
  output logic [spc_pkg::EventW-1:0]      press_event
);

  localparam int unsigned MaskW =
    (HISTORY_BITS > spc_pkg::CfgW) ? HISTORY_BITS : spc_pkg::CfgW;

  logic [MaskW-1:0] mask_wide;
  logic [MaskW-1:0] hist_wide;
  logic             pressed;
  logic [7:0]       adv1;
  logic [7:0]       adv2;
  logic [7:0]       timer_a;
  logic             close2;

  // Each window timer step adds one and closes once it passes the limit or wraps.
  assign adv1    = state.window_timer + 8'd1;
  assign timer_a = (state.window_timer == 8'd0) ? 8'd0 :
                   ((adv1 > cfg.click_window_ticks) || (adv1 == 8'd0)) ? 8'd0 : adv1;
  assign adv2    = timer_a + 8'd1;
  assign close2  = (adv2 > cfg.click_window_ticks) || (adv2 == 8'd0);

  assign history_nxt = {history[HISTORY_BITS-2:0], sample};
  assign mask_wide   = MaskW'(cfg.debounce_mask);
  assign hist_wide   = MaskW'(history_nxt);
  assign pressed     = |(mask_wide & hist_wide);

  always_comb begin
    state_nxt              = state;
    state_nxt.window_timer = timer_a;
    press_event            = spc_pkg::EV_NONE;
    if (pressed) begin
      state_nxt.was_pressed = 1'b1;
      state_nxt.hold_ticks  = state.hold_ticks + 8'd1;
      if (state_nxt.hold_ticks == cfg.long_press_ticks) begin
        state_nxt.hold_ticks        = 8'd0;
        state_nxt.long_press_active = 1'b1;
        press_event                 = spc_pkg::EV_LONG;
      end
    end else if (state.was_pressed) begin
      if (state.long_press_active) begin
        state_nxt.long_press_active = 1'b0;
      end else begin
        if (timer_a == 8'd0) begin
          state_nxt.click_count = spc_pkg::ClickW'(1);
        end else if (state.click_count != spc_pkg::CLICK_MAX) begin
          state_nxt.click_count = state.click_count + spc_pkg::ClickW'(1);
        end
        state_nxt.window_timer = 8'd1;
      end
      state_nxt.was_pressed = 1'b0;
      state_nxt.hold_ticks  = 8'd0;
    end else begin
      state_nxt.hold_ticks = 8'd0;
      if (timer_a != 8'd0) begin
        if (close2) begin
          state_nxt.window_timer = 8'd0;
          press_event = spc_pkg::EventW'(state.click_count) + spc_pkg::EventW'(1);
        end else begin
          state_nxt.window_timer = adv2;
        end
      end
    end
  end

endmodule

// File: hdl/spc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_checker
// Port-level assertions for the switch press classifier, bound to the core.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [spc_pkg::EventW-1:0] out_press_event
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_press_event))
    else $error("result changed while stalled");

  // Every accepted request yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // An empty result stage never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

  // Events never exceed the saturated click count plus one.
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_press_event <= spc_pkg::EV_MAX)
    else $error("event code out of range");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind switch_press_classifier_core spc_checker u_spc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_press_event (out_press_event)
);

// File: test/tb_switch_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_switch_press_classifier_core
// Self-checking testbench for the debounced switch press classifier.
// ----------------------------------------------------------------------------
// Raw switch samples are sent as requests on the input channel and every
// event that comes back is compared with a cycle-free behavioral predictor
// kept inside this module. The run starts with register access checks and
// a short directed sequence, then covers the corner settings (no debounce
// mask, the widest mask, a wrapping hold counter, a wrapping click window,
// click count saturation), and finishes with random gesture streams made of
// clicks, holds, idle stretches and contact bounce under random settings.
// Both channels idle at random: the sender works in bursts and the receiver
// follows stall patterns that change over time.
// ----------------------------------------------------------------------------
module tb_switch_press_classifier_core;

  localparam int unsigned HIST_BITS   = 8;
  // Cycles with no handshake at all before the run is declared hung. The
  // longest correct quiet stretch is a receiver stall pattern of all zeros
  // or a sender gap, so this is far above it.
  localparam int unsigned IDLE_LIMIT  = 3000;
  // The block answers in the cycle after a request; the tail cycles at the
  // end catch any result that shows up without a request behind it.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES     = 2;
  localparam int unsigned SAMPLES_PER_PHASE = 60;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_switch_pressed = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [spc_pkg::EventW-1:0]   out_press_event;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [spc_pkg::AddrW-1:0]    paddr = '0;
  logic [spc_pkg::DataW-1:0]    pwdata = '0;
  logic [spc_pkg::DataW-1:0]    prdata;
  logic                         pready;

  switch_press_classifier_core #(
    .HISTORY_BITS(HIST_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_switch_pressed(in_switch_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_press_event  (out_press_event),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: settings and state mirrored from the block.
  // --------------------------------------------------------------------------
  logic [spc_pkg::CfgW-1:0]   cfg_mask   = spc_pkg::RST_DEBOUNCE_MASK;
  logic [spc_pkg::CfgW-1:0]   cfg_long   = spc_pkg::RST_LONG_PRESS;
  logic [spc_pkg::CfgW-1:0]   cfg_window = spc_pkg::RST_CLICK_WINDOW;

  logic [HIST_BITS-1:0]       st_history     = '0;
  logic                       st_was_pressed = 1'b0;
  logic [7:0]                 st_hold        = '0;
  logic                       st_long_active = 1'b0;
  logic [7:0]                 st_window      = '0;
  logic [spc_pkg::ClickW-1:0] st_clicks      = '0;

  // One step of the click window timer. It closes once it runs past the
  // limit, and also when the 8-bit count wraps to zero.
  function automatic logic advance_click_window();
    st_window = st_window + 8'd1;
    if (st_window > cfg_window || st_window == 8'd0) begin
      st_window = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Classifies one raw sample and returns the event that it causes.
  function automatic logic [spc_pkg::EventW-1:0] classify_sample(input logic sample);
    logic [spc_pkg::EventW-1:0] ev;
    logic                       down;
    ev = spc_pkg::EV_NONE;
    // An open window always advances first; closing here reports nothing.
    if (st_window != 8'd0) begin
      void'(advance_click_window());
    end
    st_history = {st_history[HIST_BITS-2:0], sample};
    down = |(st_history & cfg_mask[HIST_BITS-1:0]);
    if (down) begin
      st_was_pressed = 1'b1;
      st_hold = st_hold + 8'd1;
      // A limit of zero is met only after the counter wraps.
      if (st_hold == cfg_long) begin
        st_hold = 8'd0;
        st_long_active = 1'b1;
        ev = spc_pkg::EV_LONG;
      end
    end else if (st_was_pressed) begin
      // A release after a long press just ends it; otherwise it is a click.
      if (st_long_active) begin
        st_long_active = 1'b0;
      end else begin
        if (st_window == 8'd0) begin
          st_clicks = 4'd1;
        end else if (st_clicks < spc_pkg::CLICK_MAX) begin
          st_clicks = st_clicks + 4'd1;
        end
        st_window = 8'd1;
      end
      st_was_pressed = 1'b0;
      st_hold = 8'd0;
    end else begin
      // Idle ticks advance the window a second time; expiry here reports.
      st_hold = 8'd0;
      if (st_window != 8'd0 && advance_click_window()) begin
        ev = spc_pkg::EventW'(st_clicks) + 5'd1;
      end
    end
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Inputs are driven with nonblocking assignments at the rising
  // edge, so this block sees the values that were present before the edge.
  // --------------------------------------------------------------------------
  logic [spc_pkg::EventW-1:0] pending_events[$];
  logic [spc_pkg::EventW-1:0] oldest_event;
  int unsigned                n_errors = 0;
  int unsigned                n_samples = 0;
  int unsigned                n_long_seen = 0;
  int unsigned                n_bursts_seen = 0;
  int unsigned                n_settings = 0;
  int unsigned                max_event_seen = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      // Predict first so that a result in the same cycle finds its entry.
      if (in_valid && in_ready) begin
        pending_events.push_back(classify_sample(in_switch_pressed));
        n_samples++;
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: result %0d arrived with no request outstanding",
                   $time, out_press_event);
          n_errors++;
        end else begin
          oldest_event = pending_events.pop_front();
          if (out_press_event !== oldest_event) begin
            $display("%0t: press_event mismatch, expected %0d, actual %0d",
                     $time, oldest_event, out_press_event);
            n_errors++;
          end
          if (oldest_event == spc_pkg::EV_LONG) begin
            n_long_seen++;
          end else if (oldest_event != spc_pkg::EV_NONE) begin
            n_bursts_seen++;
          end
          if (oldest_event > max_event_seen) begin
            max_event_seen = oldest_event;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no handshake of any kind completes.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_events.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready follows a 16-bit stall pattern, replaced whenever its
  // 6-bit countdown reaches zero. Some patterns never stall, some stall at
  // random and some stall on a fixed rhythm, so stalls land on every phase.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_count = '0;

  always @(posedge clk) begin
    if (stall_count == 6'd0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_pattern <= 16'hFFFF;
        end
        1: begin
          stall_pattern <= 16'($urandom);
        end
        2: begin
          stall_pattern <= 16'b1011_0110_1101_1011;
        end
        default: begin
          stall_pattern <= 16'($urandom) | 16'($urandom);
        end
      endcase
    end
    stall_count <= stall_count - 6'd1;
    out_ready <= stall_pattern[stall_count[3:0]];
  end

  // --------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length; between bursts the
  // valid line may drop for a random gap. Valid is only lowered at the start
  // of a gap or to drain, so a request that follows at once keeps valid high.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_sample(input logic sample);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        // A long stretch with no idling at all.
        burst_left = $urandom_range(40, 80);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_switch_pressed <= sample;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic send_run(input logic sample, input int unsigned len);
    repeat (len) send_sample(sample);
  endtask

  // Waits until every request has been answered. The first wait lets the
  // scoreboard record the request that was accepted at the current edge.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // One random gesture shaped by the current settings: mostly clicks and
  // holds that the debouncer lets through, plus idle stretches and bounce.
  task automatic send_gesture();
    int unsigned span;
    int unsigned eff_long;
    int unsigned half_win;
    int unsigned kind;
    // A release is only seen once every masked history bit has cleared.
    span = 1;
    for (int b = 0; b < HIST_BITS; b++) begin
      if (cfg_mask[b]) begin
        span = b + 1;
      end
    end
    eff_long = (cfg_long == 8'd0) ? 256 : cfg_long;
    half_win = cfg_window / 2;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      send_run(1'b1, $urandom_range(1, 6));
      send_run(1'b0, $urandom_range(span, span + half_win + 2));
    end else if (kind < 70) begin
      send_run(1'b1, $urandom_range(1, eff_long + eff_long / 4 + 2));
      send_run(1'b0, span + $urandom_range(0, 3));
    end else if (kind < 85) begin
      send_run(1'b0, $urandom_range(1, half_win + 4));
    end else begin
      repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_gestures(input int unsigned count);
    int unsigned target;
    target = n_samples + count;
    while (n_samples < target) begin
      send_gesture();
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration port. A write is a setup phase and an access phase; the
  // register takes the value at the edge that ends the access phase. The
  // upper data bits are random since only the low byte is kept. The select
  // line drops after every transfer.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [1:0] idx, input logic [spc_pkg::CfgW-1:0] value);
    logic [spc_pkg::DataW-1:0] word;
    word = spc_pkg::DataW'($urandom);
    word[spc_pkg::CfgW-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      spc_pkg::REG_DEBOUNCE_MASK: cfg_mask = value;
      spc_pkg::REG_LONG_PRESS:    cfg_long = value;
      default:                    cfg_window = value;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [1:0] idx, input logic [spc_pkg::CfgW-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[spc_pkg::CfgW-1:0] !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
               $time, idx, want, prdata[spc_pkg::CfgW-1:0]);
      n_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Settings only change once the block has answered everything.
  task automatic apply_settings(input logic [spc_pkg::CfgW-1:0] mask,
                                input logic [spc_pkg::CfgW-1:0] hold,
                                input logic [spc_pkg::CfgW-1:0] window);
    wait_results_drained();
    cfg_write(spc_pkg::REG_DEBOUNCE_MASK, mask);
    cfg_write(spc_pkg::REG_LONG_PRESS, hold);
    cfg_write(spc_pkg::REG_CLICK_WINDOW, window);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset values read back, then each register holds what was written.
  task automatic test_register_access();
    cfg_read(spc_pkg::REG_DEBOUNCE_MASK, spc_pkg::RST_DEBOUNCE_MASK);
    cfg_read(spc_pkg::REG_LONG_PRESS, spc_pkg::RST_LONG_PRESS);
    cfg_read(spc_pkg::REG_CLICK_WINDOW, spc_pkg::RST_CLICK_WINDOW);
    apply_settings(8'hA5, 8'h5A, 8'hC3);
    cfg_read(spc_pkg::REG_DEBOUNCE_MASK, 8'hA5);
    cfg_read(spc_pkg::REG_LONG_PRESS, 8'h5A);
    cfg_read(spc_pkg::REG_CLICK_WINDOW, 8'hC3);
  endtask

  // Single click, double click, a repeating long press and the release
  // that ends it, all with an undelayed debouncer.
  task automatic test_directed_basics();
    apply_settings(8'h01, 8'd3, 8'd6);
    send_run(1'b1, 1);
    send_run(1'b0, 5);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 5);
    send_run(1'b1, 7);
    send_run(1'b0, 3);
  endtask

  // Eighteen quick clicks keep the window open; the count stops at its
  // maximum and the burst reports the largest event once it expires.
  task automatic test_click_saturation();
    apply_settings(8'h01, 8'd50, 8'd40);
    repeat (18) begin
      send_run(1'b1, 1);
      send_run(1'b0, 1);
    end
    send_run(1'b0, 30);
  endtask

  // Corner settings: a mask that selects nothing, the widest mask with the
  // largest hold limit, a hold counter that has to wrap, a window timer that
  // wraps instead of passing its limit, and the oldest history bit alone.
  task automatic test_extreme_settings();
    apply_settings(8'h00, 8'd1, 8'd1);
    send_gestures(20);
    apply_settings(8'hFF, 8'd255, 8'd254);
    send_gestures(60);
    apply_settings(8'h01, 8'd0, 8'd255);
    send_run(1'b1, 260);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 130);
    apply_settings(8'h80, 8'd1, 8'd2);
    send_gestures(30);
  endtask

  // Random gesture streams under random settings. The sender also pauses
  // once mid-phase until every result has come back.
  task automatic test_random_gestures();
    logic [spc_pkg::CfgW-1:0] mask;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       mask = 8'h01;
        1:       mask = 8'h03;
        2:       mask = 8'h0F;
        default: mask = 8'($urandom_range(1, 255));
      endcase
      apply_settings(mask, 8'($urandom_range(2, 40)), 8'($urandom_range(2, 40)));
      send_gestures(SAMPLES_PER_PHASE / 2);
      wait_results_drained();
      send_gestures(SAMPLES_PER_PHASE / 2);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_basics();
    test_click_saturation();
    test_extreme_settings();
    test_random_gestures();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d switch samples across %0d register settings.",
             n_samples, n_settings);
    $display("Saw %0d long presses and %0d click bursts, largest event %0d.",
             n_long_seen, n_bursts_seen, max_event_seen);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
